// File: rtl/sds_pkg.sv
// Shared constants, types and month tables for the seconds-to-date converter.
package sds_pkg;

    // Reciprocal multipliers for exact division by constants.
    // x/60 = (x>>2)/15 on 30 bits: floor(x * ceil(2^34/15) / 2^34)
    localparam logic [30:0] DIV60A_MUL = 31'd1145324613;
    localparam int unsigned DIV60A_SHIFT = 34;
    // x/60 = (x>>2)/15 on 25 bits: floor(x * ceil(2^28/15) / 2^28)
    localparam logic [24:0] DIV60B_MUL = 25'd17895698;
    localparam int unsigned DIV60B_SHIFT = 28;
    // x/24 = (x>>3)/3 on 18 bits: floor(x * ceil(2^20/3) / 2^20)
    localparam logic [18:0] DIV24_MUL = 19'd349526;
    localparam int unsigned DIV24_SHIFT = 20;
    // x/1461 on 16 bits: floor(x * ceil(2^27/1461) / 2^27)
    localparam logic [16:0] DIV1461_MUL = 17'd91868;
    localparam int unsigned DIV1461_SHIFT = 27;
    // x/365 on 16 bits: floor(x * ceil(2^25/365) / 2^25)
    localparam logic [16:0] DIV365_MUL = 17'd91930;
    localparam int unsigned DIV365_SHIFT = 25;

    localparam logic [15:0] LEAP_BIAS = 16'd1096;   // 3*365 + 1
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [11:0] BASE_YEAR = 12'd2000;
    localparam int unsigned MONTHS = 12;
    localparam logic [3:0]  LAST_MONTH = 4'd12;
    localparam logic [4:0]  LAST_DAY = 5'd31;

    // Last day of year of each month, and day count before each month.
    localparam logic [8:0] MONTH_END_NORM [MONTHS] =
        '{9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
    localparam logic [8:0] MONTH_END_LEAP [MONTHS] =
        '{9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
          9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};
    localparam logic [8:0] MONTH_START_NORM [MONTHS] =
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
          9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
    localparam logic [8:0] MONTH_START_LEAP [MONTHS] =
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
          9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_tod;

endpackage

// File: rtl/seconds_since_2000_to_date.sv
// Top level: seconds since 2000-01-01 00:00:00 to calendar date and time.
//
// Converts a 32-bit count of seconds since 2000-01-01 00:00:00 into year,
// month, day, hours, minutes and seconds. The block accepts one transfer
// per clock when the output side does not stall; every stage is one
// register deep and holds one reciprocal multiplier or one add-and-compare,
// so the clock rate is set by the widest multiplier (30 by 31 bits, in the
// first stage). Stalls back up stage by stage: a stage that holds a bubble
// still takes a new item, so o_stall rises only when all eight stages are
// full. Every year divisible by four is a leap year, so dates are exact
// through 2099 and follow the same rule up to the top of the input range
// in 2136.
module seconds_since_2000_to_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_timestamp_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hours,
    output logic [5:0]  o_minutes,
    output logic [5:0]  o_seconds
);
    import sds_pkg::*;

    // Time-of-day to year handshake
    logic        w_tod_valid;
    logic        w_tod_stall;
    logic [15:0] w_days;
    t_tod        w_tod_a;

    // Year to month handshake
    logic        w_yr_valid;
    logic        w_yr_stall;
    logic [7:0]  w_yr;
    logic [8:0]  w_doy;
    logic        w_leap;
    t_tod        w_tod_b;

    t_tod        w_tod_out;

    // Split off seconds, minutes and hours; leave a whole day count
    sds_tod u_tod (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_timestamp_seconds (i_timestamp_seconds),
        .o_valid             (w_tod_valid),
        .i_stall             (w_tod_stall),
        .o_days              (w_days),
        .o_tod               (w_tod_a)
    );

    // Resolve the year through the four-year cycle, then the day of year
    sds_year u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tod_valid),
        .o_stall (w_tod_stall),
        .i_days  (w_days),
        .i_tod   (w_tod_a),
        .o_valid (w_yr_valid),
        .i_stall (w_yr_stall),
        .o_yr    (w_yr),
        .o_doy   (w_doy),
        .o_leap  (w_leap),
        .o_tod   (w_tod_b)
    );

    // Look up month and day of month; hold the result for the output transfer
    sds_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_yr_valid),
        .o_stall (w_yr_stall),
        .i_yr    (w_yr),
        .i_doy   (w_doy),
        .i_leap  (w_leap),
        .i_tod   (w_tod_b),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day),
        .o_tod   (w_tod_out)
    );

    assign o_hours   = w_tod_out.hours;
    assign o_minutes = w_tod_out.minutes;
    assign o_seconds = w_tod_out.seconds;
endmodule

// File: rtl/sds_tod.sv
// Time-of-day split: seconds, minutes, hours and whole day count, four stages.
module sds_tod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [31:0]         i_timestamp_seconds,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [15:0]         o_days,
    output sds_pkg::t_tod       o_tod
);
    import sds_pkg::*;

    logic        r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic        w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;

    logic [60:0] r_p1;
    logic [5:0]  r_t_lo;
    logic [49:0] r_p2;
    logic [26:0] r_q1;
    logic [5:0]  r_sec_b;
    logic [36:0] r_p3;
    logic [4:0]  r_q2_lo;
    logic [5:0]  r_min_c;
    logic [5:0]  r_sec_c;
    logic [15:0] r_days;
    t_tod        r_tod;

    logic [60:0] n_p1;
    logic [26:0] w_q1;
    logic [49:0] n_p2;
    logic [5:0]  n_sec;
    logic [20:0] w_q2;
    logic [36:0] n_p3;
    logic [5:0]  n_min;
    logic [15:0] w_days;
    logic [4:0]  n_hr;

    assign w_rdy_d = !r_vld_d || !i_stall;
    assign w_rdy_c = !r_vld_c || w_rdy_d;
    assign w_rdy_b = !r_vld_b || w_rdy_c;
    assign w_rdy_a = !r_vld_a || w_rdy_b;
    assign o_stall = !w_rdy_a;

    // q1 = t/60; remainder from t - 60*q1 = t + 4*q1 (mod 64)
    assign n_p1  = 61'(i_timestamp_seconds[31:2]) * 61'(DIV60A_MUL);
    assign w_q1  = r_p1[DIV60A_SHIFT +: 27];
    assign n_sec = r_t_lo + {w_q1[3:0], 2'b00};
    assign n_p2  = 50'(w_q1[26:2]) * 50'(DIV60B_MUL);
    // q2 = q1/60
    assign w_q2  = r_p2[DIV60B_SHIFT +: 21];
    assign n_min = r_q1[5:0] + {w_q2[3:0], 2'b00};
    assign n_p3  = 37'(w_q2[20:3]) * 37'(DIV24_MUL);
    // days = q2/24; hours = q2 - 24*days = q2 + 8*days (mod 32)
    assign w_days = r_p3[DIV24_SHIFT +: 16];
    assign n_hr   = r_q2_lo + {w_days[1:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (w_rdy_a) r_vld_a <= i_valid;
            if (w_rdy_b) r_vld_b <= r_vld_a;
            if (w_rdy_c) r_vld_c <= r_vld_b;
            if (w_rdy_d) r_vld_d <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_p1   <= n_p1;
            r_t_lo <= i_timestamp_seconds[5:0];
        end
        if (w_rdy_b && r_vld_a) begin
            r_p2    <= n_p2;
            r_q1    <= w_q1;
            r_sec_b <= n_sec;
        end
        if (w_rdy_c && r_vld_b) begin
            r_p3    <= n_p3;
            r_q2_lo <= w_q2[4:0];
            r_min_c <= n_min;
            r_sec_c <= r_sec_b;
        end
        if (w_rdy_d && r_vld_c) begin
            r_days        <= w_days;
            r_tod.hours   <= n_hr;
            r_tod.minutes <= r_min_c;
            r_tod.seconds <= r_sec_c;
        end
    end

    assign o_valid = r_vld_d;
    assign o_days  = r_days;
    assign o_tod   = r_tod;
endmodule

// File: rtl/sds_year.sv
// Year and day-of-year from the day count, three stages.
module sds_year (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [15:0]         i_days,
    input  sds_pkg::t_tod       i_tod,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_yr,
    output logic [8:0]          o_doy,
    output logic                o_leap,
    output sds_pkg::t_tod       o_tod
);
    import sds_pkg::*;

    logic        r_vld_e, r_vld_f, r_vld_g;
    logic        w_rdy_e, w_rdy_f, w_rdy_g;

    logic [32:0] r_p4;
    logic [15:0] r_days_e;
    t_tod        r_tod_e;
    logic [32:0] r_p5;
    logic [15:0] r_days_f;
    t_tod        r_tod_f;
    logic [7:0]  r_yr;
    logic [8:0]  r_doy;
    logic        r_leap;
    t_tod        r_tod_g;

    logic [32:0] n_p4;
    logic [5:0]  w_leaps;
    logic [15:0] w_dl;
    logic [32:0] n_p5;
    logic [7:0]  w_yr;
    logic [16:0] w_yr_days;
    logic [16:0] n_doy;

    assign w_rdy_g = !r_vld_g || !i_stall;
    assign w_rdy_f = !r_vld_f || w_rdy_g;
    assign w_rdy_e = !r_vld_e || w_rdy_f;
    assign o_stall = !w_rdy_e;

    // Completed leap days, then the year offset
    assign n_p4    = 33'(i_days + LEAP_BIAS) * 33'(DIV1461_MUL);
    assign w_leaps = r_p4[DIV1461_SHIFT +: 6];
    assign w_dl    = r_days_e - 16'(w_leaps);
    assign n_p5    = 33'(w_dl) * 33'(DIV365_MUL);
    assign w_yr    = r_p5[DIV365_SHIFT +: 8];
    // First day of the year: yr*365 + (yr+3)/4
    assign w_yr_days = 17'(w_yr) * 17'(DAYS_PER_YEAR)
                     + 17'((9'(w_yr) + 9'd3) >> 2);
    assign n_doy     = 17'(r_days_f) - w_yr_days + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e <= 1'b0;
            r_vld_f <= 1'b0;
            r_vld_g <= 1'b0;
        end else begin
            if (w_rdy_e) r_vld_e <= i_valid;
            if (w_rdy_f) r_vld_f <= r_vld_e;
            if (w_rdy_g) r_vld_g <= r_vld_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_e && i_valid) begin
            r_p4     <= n_p4;
            r_days_e <= i_days;
            r_tod_e  <= i_tod;
        end
        if (w_rdy_f && r_vld_e) begin
            r_p5     <= n_p5;
            r_days_f <= r_days_e;
            r_tod_f  <= r_tod_e;
        end
        if (w_rdy_g && r_vld_f) begin
            r_yr    <= w_yr;
            r_doy   <= n_doy[8:0];
            r_leap  <= (w_yr[1:0] == 2'b00);
            r_tod_g <= r_tod_f;
        end
    end

    assign o_valid = r_vld_g;
    assign o_yr    = r_yr;
    assign o_doy   = r_doy;
    assign o_leap  = r_leap;
    assign o_tod   = r_tod_g;
endmodule

// File: rtl/sds_month.sv
// Month and day-of-month lookup plus the registered result stage.
module sds_month (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_yr,
    input  logic [8:0]          i_doy,
    input  logic                i_leap,
    input  sds_pkg::t_tod       i_tod,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [11:0]         o_year,
    output logic [3:0]          o_month,
    output logic [4:0]          o_day,
    output sds_pkg::t_tod       o_tod
);
    import sds_pkg::*;

    logic        r_vld_h;
    logic        w_rdy_h;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    t_tod        r_tod;

    logic [3:0]  n_month;
    logic [4:0]  n_day;

    assign w_rdy_h = !r_vld_h || !i_stall;
    assign o_stall = !w_rdy_h;

    // First month whose end reaches the day of year; scan downward so the
    // earliest match wins.
    always_comb begin
        logic [8:0] v_end;
        logic [8:0] v_start;
        n_month = LAST_MONTH;
        n_day   = LAST_DAY;
        for (int i = MONTHS - 1; i >= 0; i--) begin
            v_end   = i_leap ? MONTH_END_LEAP[i] : MONTH_END_NORM[i];
            v_start = i_leap ? MONTH_START_LEAP[i] : MONTH_START_NORM[i];
            if (i_doy <= v_end) begin
                n_month = 4'(i + 1);
                n_day   = 5'(i_doy - v_start);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_h <= 1'b0;
        end else if (w_rdy_h) begin
            r_vld_h <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_h && i_valid) begin
            r_year  <= 12'(i_yr) + BASE_YEAR;
            r_month <= n_month;
            r_day   <= n_day;
            r_tod   <= i_tod;
        end
    end

    assign o_valid = r_vld_h;
    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;
    assign o_tod   = r_tod;
endmodule
